@@ design/pcsc_pkg.sv @@
// shared types, constants and functions of the png chunk stream checker
package pcsc_pkg;

    localparam int SIG_LEN   = 8;
    localparam int NUM_KNOWN = 27;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [31:0] TYPE_IHDR = "IHDR";
    localparam logic [31:0] TYPE_PLTE = "PLTE";
    localparam logic [31:0] TYPE_IDAT = "IDAT";
    localparam logic [31:0] TYPE_IEND = "IEND";
    localparam logic [31:0] TYPE_OFFS = "oFFs";
    localparam logic [31:0] TYPE_PCAL = "pCAL";
    localparam logic [31:0] TYPE_SCAL = "sCAL";

    localparam logic [31:0] KNOWN_TYPES [NUM_KNOWN] = '{
        "IHDR", "PLTE", "IDAT", "IEND", "tRNS", "gAMA", "cHRM", "sRGB", "iCCP",
        "tEXt", "zTXt", "iTXt", "bKGD", "pHYs", "sBIT", "sPLT", "hIST", "tIME",
        "fRAc", "gIFg", "gIFt", "gIFx", "oFFs", "pCAL", "sCAL", "sTER", "vpAg"
    };

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CRC_ERR    = 3'd1,
        ST_UNKNOWN    = 3'd2,
        ST_BEFORE_HDR = 3'd3,
        ST_ORDER_ERR  = 3'd4,
        ST_BAD_SIG    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ORD_NONE = 2'd0,
        ORD_HDR  = 2'd1,
        ORD_PLTE = 2'd2,
        ORD_IDAT = 2'd3
    } order_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic        halted;
    } result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic is_known_type(input logic [31:0] t);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_KNOWN; i++) begin
            hit = hit | (t == KNOWN_TYPES[i]);
        end
        return hit;
    endfunction

endpackage

@@ design/pcsc_in_reg.sv @@
// input register for incoming file bytes
module pcsc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           s_first_of_file,
    input  logic           advance,
    output logic           item_valid,
    output pcsc_pkg::item_t item
);
    import pcsc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{data_byte: s_data_byte, first_of_file: s_first_of_file};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/pcsc_parser.sv @@
// chunk parser state, crc-32 update and chunk classification
module pcsc_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  pcsc_pkg::item_t   item,
    output logic              res_valid,
    output pcsc_pkg::result_t res
);
    import pcsc_pkg::*;

    phase_t      phase_reg,   phase_next,   phase_cur;
    logic [31:0] count_reg,   count_next,   count_cur;
    logic [31:0] len_reg,     len_next,     len_cur;
    logic [31:0] type_reg,    type_next,    type_cur;
    logic [31:0] crc_reg,     crc_next,     crc_cur;
    logic [31:0] crc_rx_reg,  crc_rx_next,  crc_rx_cur;
    order_t      order_reg,   order_next,   order_cur;
    logic        stopped_reg, stopped_next, stopped_cur;

    logic [7:0]  b;
    logic [31:0] count_inc;
    logic [31:0] rx_full;
    status_t     st;

    assign b = item.data_byte;

    // restart flag acts as a reset seen by this transaction
    always_comb begin
        if (item.first_of_file) begin
            phase_cur   = PH_SIG;
            count_cur   = '0;
            len_cur     = '0;
            type_cur    = '0;
            crc_cur     = CRC_INIT;
            crc_rx_cur  = '0;
            order_cur   = ORD_NONE;
            stopped_cur = 1'b0;
        end else begin
            phase_cur   = phase_reg;
            count_cur   = count_reg;
            len_cur     = len_reg;
            type_cur    = type_reg;
            crc_cur     = crc_reg;
            crc_rx_cur  = crc_rx_reg;
            order_cur   = order_reg;
            stopped_cur = stopped_reg;
        end
    end

    assign count_inc = count_cur + 32'd1;
    assign rx_full   = {crc_rx_cur[23:0], b};

    always_comb begin
        phase_next   = phase_cur;
        count_next   = count_cur;
        len_next     = len_cur;
        type_next    = type_cur;
        crc_next     = crc_cur;
        crc_rx_next  = crc_rx_cur;
        order_next   = order_cur;
        stopped_next = stopped_cur;
        res_valid    = 1'b0;
        st           = ST_OK;
        res          = '{status: ST_OK, chunk_type: '0, chunk_length: '0, halted: 1'b0};

        if (!stopped_cur) begin
            unique case (phase_cur)
                PH_SIG: begin
                    if (b != SIG_BYTES[count_cur[2:0]]) begin
                        stopped_next = 1'b1;
                        res_valid    = 1'b1;
                        res          = '{status: ST_BAD_SIG, chunk_type: '0,
                                         chunk_length: '0, halted: 1'b1};
                    end else if (count_cur[2:0] == 3'(SIG_LEN - 1)) begin
                        phase_next = PH_LEN;
                        count_next = '0;
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_LEN: begin
                    len_next = {len_cur[23:0], b};
                    if (count_cur == 32'd3) begin
                        phase_next = PH_TYPE;
                        count_next = '0;
                        crc_next   = CRC_INIT;
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_TYPE: begin
                    type_next = {type_cur[23:0], b};
                    crc_next  = crc32_byte(crc_cur, b);
                    if (count_cur == 32'd3) begin
                        count_next = '0;
                        phase_next = (len_cur != '0) ? PH_DATA : PH_CRC;
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_DATA: begin
                    crc_next = crc32_byte(crc_cur, b);
                    if (count_inc == len_cur) begin
                        phase_next = PH_CRC;
                        count_next = '0;
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_CRC: begin
                    crc_rx_next = rx_full;
                    if (count_cur != 32'd3) begin
                        count_next = count_inc;
                    end else begin
                        count_next = '0;
                        phase_next = PH_LEN;
                        res_valid  = 1'b1;
                        priority if (~crc_cur != rx_full) begin
                            stopped_next = 1'b1;
                            st           = ST_CRC_ERR;
                        end else if (!is_known_type(type_cur)) begin
                            st = ST_UNKNOWN;
                        end else if (type_cur == TYPE_IHDR) begin
                            st         = (order_cur != ORD_NONE) ? ST_ORDER_ERR : ST_OK;
                            order_next = ORD_HDR;
                        end else if (order_cur == ORD_NONE) begin
                            st = ST_BEFORE_HDR;
                        end else if (type_cur == TYPE_PLTE) begin
                            st         = (order_cur == ORD_PLTE || order_cur == ORD_IDAT)
                                         ? ST_ORDER_ERR : ST_OK;
                            order_next = ORD_PLTE;
                        end else if (type_cur == TYPE_IDAT) begin
                            order_next = ORD_IDAT;
                        end else if (type_cur == TYPE_IEND) begin
                            stopped_next = 1'b1;
                        end else if (type_cur == TYPE_OFFS || type_cur == TYPE_PCAL ||
                                     type_cur == TYPE_SCAL) begin
                            st = (order_cur == ORD_IDAT) ? ST_ORDER_ERR : ST_OK;
                        end else begin
                            st = ST_OK;
                        end
                        res = '{status: st, chunk_type: type_cur,
                                chunk_length: len_cur, halted: stopped_next};
                    end
                end
                default: begin
                    phase_next = PH_SIG;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            count_reg   <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            crc_reg     <= CRC_INIT;
            crc_rx_reg  <= '0;
            order_reg   <= ORD_NONE;
            stopped_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            crc_reg     <= crc_next;
            crc_rx_reg  <= crc_rx_next;
            order_reg   <= order_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

@@ design/pcsc_out_reg.sv @@
// result register towards the result channel
module pcsc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              res_valid,
    input  pcsc_pkg::result_t res,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [31:0]       m_chunk_type,
    output logic [31:0]       m_chunk_length,
    output logic              m_halted
);
    import pcsc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? (step && res_valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = res_reg.status;
    assign m_chunk_type   = res_reg.chunk_type;
    assign m_chunk_length = res_reg.chunk_length;
    assign m_halted       = res_reg.halted;

endmodule

@@ design/png_chunk_stream_checker.sv @@
// top level of the png chunk stream checker
//
//  channel  direction  signals                                         role
//  s_       in         s_valid s_ready s_data_byte s_first_of_file     file bytes
//  m_       out        m_valid m_ready m_status m_chunk_type           chunk reports
//                      m_chunk_length m_halted
//
//  one byte per cycle while the result register is not stalled; a byte passes
//  an input register, then the parser and crc-32 byte update, then the result register
//  reset: aresetn synchronous, active low, back in signature phase
//  a stalled result register holds the parser and the input register; the
//  input register still takes a byte while it is empty
module png_chunk_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_chunk_type,
    output logic [31:0] m_chunk_length,
    output logic        m_halted
);
    import pcsc_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    step;
    logic    res_valid;
    result_t res;

    assign step = item_valid && advance;

    pcsc_in_reg u_in_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_first_of_file (s_first_of_file),
        .advance         (advance),
        .item_valid      (item_valid),
        .item            (item)
    );

    pcsc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pcsc_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .res_valid      (res_valid),
        .res            (res),
        .advance        (advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_chunk_type   (m_chunk_type),
        .m_chunk_length (m_chunk_length),
        .m_halted       (m_halted)
    );

endmodule

@@ tb/sv/tb_png_chunk_stream_checker.sv @@
// testbench of the png chunk stream checker: byte stream stimulus, chunk report prediction
`timescale 1ns / 100ps

module tb_png_chunk_stream_checker;
    import pcsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 10;
    localparam int STALL_CYCLES   = 250;
    localparam int RANDOM_ITEMS   = 480;

    localparam logic [31:0] TYPE_TEXT = "tEXt";
    localparam logic [31:0] TYPE_GAMA = "gAMA";
    localparam logic [31:0] TYPE_JUNK = "zzzz";
    localparam logic [31:0] ORDER_TYPES [6] = '{
        TYPE_IHDR, TYPE_PLTE, TYPE_IDAT, TYPE_OFFS, TYPE_PCAL, TYPE_SCAL
    };

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_of_file;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_chunk_type;
    logic [31:0] m_chunk_length;
    logic        m_halted;

    // stream tracker state
    phase_t      tr_phase;
    logic [31:0] tr_count;
    logic [31:0] tr_len;
    logic [31:0] tr_type;
    logic [31:0] tr_crc;
    logic [31:0] tr_crc_rx;
    order_t      tr_order;
    logic        tr_halted;

    logic [31:0] crc_lut [256];
    bit          known_set [logic [31:0]];
    result_t     chunk_reports_due [$];
    logic [7:0]  file_bytes [$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int stall_left;
    int useful_bytes;
    int mismatch_count;
    int quiet_cycles;

    png_chunk_stream_checker dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_first_of_file (s_first_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_chunk_type    (m_chunk_type),
        .m_chunk_length  (m_chunk_length),
        .m_halted        (m_halted)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic void build_tables();
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            crc_lut[i] = c;
        end
        for (int i = 0; i < NUM_KNOWN; i++) begin
            known_set[KNOWN_TYPES[i]] = 1'b1;
        end
    endfunction

    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        return crc_lut[c[7:0] ^ b] ^ (c >> 8);
    endfunction

    function automatic void clear_stream_state();
        tr_phase  = PH_SIG;
        tr_count  = '0;
        tr_len    = '0;
        tr_type   = '0;
        tr_crc    = CRC_INIT;
        tr_crc_rx = '0;
        tr_order  = ORD_NONE;
        tr_halted = 1'b0;
    endfunction

    function automatic void log_report(input status_t st, input logic [31:0] t,
                                       input logic [31:0] len);
        result_t r;
        r.status       = st;
        r.chunk_type   = t;
        r.chunk_length = len;
        r.halted       = tr_halted;
        chunk_reports_due.push_back(r);
    endfunction

    function automatic status_t rank_chunk(input logic [31:0] t);
        status_t st;
        st = ST_OK;
        if (!known_set.exists(t)) return ST_UNKNOWN;
        if (t == TYPE_IHDR) begin
            if (tr_order != ORD_NONE) st = ST_ORDER_ERR;
            tr_order = ORD_HDR;
            return st;
        end
        if (tr_order == ORD_NONE) return ST_BEFORE_HDR;
        if (t == TYPE_PLTE) begin
            if (tr_order >= ORD_PLTE) st = ST_ORDER_ERR;
            tr_order = ORD_PLTE;
        end else if (t == TYPE_IDAT) begin
            tr_order = ORD_IDAT;
        end else if (t == TYPE_IEND) begin
            tr_halted = 1'b1;
        end else if (t == TYPE_OFFS || t == TYPE_PCAL || t == TYPE_SCAL) begin
            if (tr_order == ORD_IDAT) st = ST_ORDER_ERR;
        end
        return st;
    endfunction

    // returns 1 when the byte was not ignored
    function automatic bit follow_stream_byte(input logic [7:0] b, input logic first);
        status_t st;
        if (first) clear_stream_state();
        if (tr_halted) return 1'b0;
        case (tr_phase)
            PH_SIG: begin
                if (b != SIG_BYTES[tr_count[2:0]]) begin
                    tr_halted = 1'b1;
                    log_report(ST_BAD_SIG, 32'd0, 32'd0);
                end else begin
                    tr_count++;
                    if (tr_count >= SIG_LEN) begin
                        tr_phase = PH_LEN;
                        tr_count = '0;
                    end
                end
            end
            PH_LEN: begin
                tr_len = {tr_len[23:0], b};
                tr_count++;
                if (tr_count == 4) begin
                    tr_phase = PH_TYPE;
                    tr_count = '0;
                    tr_crc   = CRC_INIT;
                end
            end
            PH_TYPE: begin
                tr_type = {tr_type[23:0], b};
                tr_crc  = crc_next(tr_crc, b);
                tr_count++;
                if (tr_count == 4) begin
                    tr_count = '0;
                    if (tr_len != 0) tr_phase = PH_DATA;
                    else tr_phase = PH_CRC;
                end
            end
            PH_DATA: begin
                tr_crc = crc_next(tr_crc, b);
                tr_count++;
                if (tr_count == tr_len) begin
                    tr_phase = PH_CRC;
                    tr_count = '0;
                end
            end
            PH_CRC: begin
                tr_crc_rx = {tr_crc_rx[23:0], b};
                tr_count++;
                if (tr_count == 4) begin
                    tr_count = '0;
                    tr_phase = PH_LEN;
                    if ((tr_crc ^ CRC_INIT) != tr_crc_rx) begin
                        tr_halted = 1'b1;
                        st = ST_CRC_ERR;
                    end else begin
                        st = rank_chunk(tr_type);
                    end
                    log_report(st, tr_type, tr_len);
                end
            end
            default: begin
                tr_phase = PH_SIG;
                tr_count = '0;
            end
        endcase
        return 1'b1;
    endfunction

    // file image builders
    function automatic void add_u32(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[i*8 +: 8]);
    endfunction

    function automatic void add_sig();
        for (int i = 0; i < SIG_LEN; i++) file_bytes.push_back(SIG_BYTES[i]);
    endfunction

    function automatic void add_chunk(input logic [31:0] ctype, input logic [31:0] len,
                                      input fill_t fill, input bit bad_crc);
        logic [31:0] c;
        logic [7:0]  d;
        c = CRC_INIT;
        add_u32(len);
        add_u32(ctype);
        for (int i = 3; i >= 0; i--) c = crc_next(c, ctype[i*8 +: 8]);
        for (int unsigned i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: d = 8'h00;
                FILL_ONES: d = 8'hFF;
                default:   d = 8'($urandom);
            endcase
            c = crc_next(c, d);
            file_bytes.push_back(d);
        end
        c = c ^ CRC_INIT;
        if (bad_crc) c = c ^ (32'd1 << $urandom_range(31));
        add_u32(c);
    endfunction

    function automatic logic [31:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 55) return KNOWN_TYPES[$urandom_range(NUM_KNOWN - 1)];
        if (r < 80) return ORDER_TYPES[$urandom_range(5)];
        if (r < 90) return TYPE_IDAT;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(8);
        if (r < 98) return $urandom_range(40, 9);
        return $urandom_range(150, 41);
    endfunction

    function automatic void build_random_file();
        int         cut;
        int         pos;
        logic [7:0] bad;
        file_bytes.delete();
        if ($urandom_range(99) < 85) begin
            add_sig();
            if ($urandom_range(99) < 85) add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
            repeat ($urandom_range(7, 1)) begin
                add_chunk(pick_type(), pick_length(), FILL_RANDOM, $urandom_range(99) < 4);
            end
            if ($urandom_range(99) < 75) begin
                add_chunk(TYPE_IEND, 0, FILL_RANDOM, $urandom_range(99) < 4);
            end
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(file_bytes.size() - 1, 1);
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end else if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(6, 1)) file_bytes.push_back(8'($urandom));
            end
        end else begin
            pos = $urandom_range(SIG_LEN - 1);
            for (int i = 0; i < pos; i++) file_bytes.push_back(SIG_BYTES[i]);
            bad = 8'($urandom);
            if (bad == SIG_BYTES[pos]) bad = ~bad;
            file_bytes.push_back(bad);
            repeat ($urandom_range(10)) file_bytes.push_back(8'($urandom));
        end
    endfunction

    // one byte transaction on the input channel, entered after a rising edge
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_first_of_file <= first;
        do @(posedge aclk); while (!s_ready);
        if (follow_stream_byte(b, first)) useful_bytes++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
        file_bytes.delete();
    endtask

    task automatic wait_all_reported();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (chunk_reports_due.size() != 0) @(negedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_report();
        result_t want;
        if (chunk_reports_due.size() == 0) begin
            report_mismatch($sformatf("report with none due: status %0d type %h length %h",
                                      m_status, m_chunk_type, m_chunk_length));
            return;
        end
        want = chunk_reports_due.pop_front();
        if (m_status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
        if (m_chunk_type != want.chunk_type)
            report_mismatch($sformatf("chunk type %h, want %h", m_chunk_type,
                                      want.chunk_type));
        if (m_chunk_length != want.chunk_length)
            report_mismatch($sformatf("chunk length %h, want %h", m_chunk_length,
                                      want.chunk_length));
        if (m_halted != want.halted)
            report_mismatch($sformatf("halted %b, want %b", m_halted, want.halted));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_report();
    end

    always @(negedge aclk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_png_chunk_stream_checker failed");
                $finish;
            end
        end
    end

    task automatic test_signature_errors();
        for (int pos = 0; pos < SIG_LEN; pos += 3) begin
            for (int k = 0; k < pos; k++) send_byte(SIG_BYTES[k], k == 0);
            send_byte(SIG_BYTES[pos] ^ 8'hFF, pos == 0);
            send_byte(8'h89, 1'b0);
            send_byte(8'h00, 1'b0);
        end
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_chunk_order();
        add_sig();
        add_chunk(TYPE_TEXT, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_JUNK, 2, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IHDR, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_OFFS, 1, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_PLTE, 3, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_PLTE, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IDAT, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_PLTE, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_OFFS, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_PCAL, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_SCAL, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_GAMA, 4, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_JUNK, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b0);
        add_u32(32'h0102_0304);
        send_file();
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_PCAL, 2, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_SCAL, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IDAT, 5, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IDAT, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b0);
        send_file();
    endtask

    task automatic test_crc_errors();
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_TEXT, 5, FILL_RANDOM, 1'b1);
        add_u32(32'hDEAD_BEEF);
        send_file();
        add_sig();
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b1);
        send_file();
    endtask

    task automatic test_restarts();
        for (int k = 0; k < 3; k++) file_bytes.push_back(SIG_BYTES[k]);
        send_file();
        add_sig();
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        send_file();
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_u32(32'd5);
        file_bytes.push_back("I");
        file_bytes.push_back("D");
        send_file();
        // headers with large lengths, cut short by the next file
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_u32(32'hFFFF_FFFF);
        add_u32(TYPE_IDAT);
        repeat (6) file_bytes.push_back(8'($urandom));
        send_file();
        add_sig();
        add_u32(32'h8000_0000);
        add_u32(TYPE_TEXT);
        repeat (3) file_bytes.push_back(8'($urandom));
        send_file();
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_TEXT, 4, FILL_RANDOM, 1'b0);
        void'(file_bytes.pop_back());
        void'(file_bytes.pop_back());
        send_file();
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IDAT, 7, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b0);
        send_file();
    endtask

    task automatic test_field_extremes();
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_ZERO, 1'b0);
        add_chunk(TYPE_TEXT, 40, FILL_ONES, 1'b0);
        add_chunk(32'h0000_0000, 1, FILL_ZERO, 1'b0);
        add_chunk(32'hFFFF_FFFF, 1, FILL_ONES, 1'b0);
        add_chunk(TYPE_IDAT, 300, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b0);
        send_file();
    endtask

    task automatic test_backpressure();
        stall_request = STALL_CYCLES;
        add_sig();
        add_chunk(TYPE_IHDR, 13, FILL_RANDOM, 1'b0);
        repeat (30) add_chunk(TYPE_TEXT, 0, FILL_RANDOM, 1'b0);
        add_chunk(TYPE_IEND, 0, FILL_RANDOM, 1'b0);
        send_file();
        wait_all_reported();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int item_target);
        int start_count;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        start_count   = useful_bytes;
        while (useful_bytes - start_count < item_target) begin
            if ($urandom_range(99) < 6) begin
                repeat ($urandom_range(12, 1)) begin
                    send_byte(8'($urandom), $urandom_range(3) == 0);
                end
            end else begin
                build_random_file();
                send_file();
            end
            if ($urandom_range(99) < 5) wait_all_reported();
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data_byte     = 8'h00;
        s_first_of_file = 1'b0;
        m_ready         = 1'b0;
        stall_request   = 0;
        stall_left      = 0;
        useful_bytes    = 0;
        mismatch_count  = 0;
        send_idle_pct   = 23;
        recv_idle_pct   = 73;
        build_tables();
        clear_stream_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_signature_errors();
        test_chunk_order();
        test_crc_errors();
        test_restarts();
        test_field_extremes();
        test_backpressure();
        test_random_traffic(23, 73, RANDOM_ITEMS / 3);
        test_random_traffic(73, 23, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        wait_all_reported();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_png_chunk_stream_checker passed");
        end else begin
            $display("tb_png_chunk_stream_checker failed");
        end
        $finish;
    end

endmodule
